>>> sv/ffpa_pkg.sv
// ---------------------------------------------------------------------------
// First-fit page allocator package
// Request kinds and status codes.
// ---------------------------------------------------------------------------
package ffpa_pkg;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_FREE  = 2'd2,
        REQ_BAD   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ZERO  = 3'd1,
        ST_NOFIT = 3'd2,
        ST_FULL  = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

endpackage

>>> sv/ffpa_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One address for write and read; registered read data, old contents during a write.
// ---------------------------------------------------------------------------
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/first_fit_page_allocator.sv
// ---------------------------------------------------------------------------
// First-fit page allocator
// Address-sorted table of free page runs in one RAM, with coalescing free.
// ---------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         request item: req_type, base_page, page_count
// m_axis    out        result item: status, alloc_start, free_pages_left, runs
//
// One request at a time. Each table entry is read in two steps (S_SREQ puts out
// the address, S_SCHK sees the registered data), and a shifted entry takes two more
// (S_MREQ, S_MMOV). A shift lies between where the scan stopped and the table end,
// so the two together visit each entry about once.
// Reset clears the run count and free total; table contents need no clearing.
// The result sits in an output register; the next request is taken once it is.
module first_fit_page_allocator #(
    parameter int NUM_PAGES = 16384,
    parameter int MAX_RUNS  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // req_type[1:0], base_page[15:2], page_count[30:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[2:0], alloc_start[16:3],
                                        // free_pages_left[31:17], runs_in_table[40:32]
);

    localparam int AW = $clog2(MAX_RUNS);
    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam int PW = $clog2(NUM_PAGES + 1);
    localparam int EW = PW + PW;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SREQ  = 8'b00000010,
        S_SCHK  = 8'b00000100,
        S_DEC   = 8'b00001000,
        S_MREQ  = 8'b00010000,
        S_MMOV  = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg;
    logic [PW-1:0]          total_reg;
    logic [1:0]             kind_reg;
    logic [PW-1:0]          base_reg;
    logic [PW-1:0]          cnt_reg;
    logic [CW-1:0]          idx_reg;
    logic [PW-1:0]          pstart_reg, plen_reg;
    logic                   pvalid_reg;
    logic [PW-1:0]          cstart_reg, clen_reg;
    logic [CW-1:0]          mv_reg;       // shift cursor
    logic                   mv_up_reg;
    logic [CW-1:0]          mv_end_reg;
    logic [EW-1:0]          fin_ent_reg;  // final write
    logic [CW-1:0]          fin_addr_reg;
    logic                   fin_we_reg;
    logic [2:0]             ost_reg;
    logic [13:0]            oas_reg;
    logic                   ovalid_reg;

    logic                   we;
    logic [AW-1:0]          addr;
    logic [EW-1:0]          wdata, rdata;
    logic [PW-1:0]          rstart, rlen;

    assign rstart = rdata[EW-1:PW];
    assign rlen   = rdata[PW-1:0];

    ffpa_ram #(.WIDTH(EW), .DEPTH(MAX_RUNS)) u_table (
        .clk  (clk),
        .we   (we),
        .addr (addr),
        .wdata(wdata),
        .rdata(rdata)
    );

    logic [1:0]     in_kind;
    logic [PW:0]    in_base, in_cnt, in_end;
    assign in_kind = s_axis_tdata[1:0];
    assign in_base = (PW + 1)'(s_axis_tdata[15:2]);
    assign in_cnt  = (PW + 1)'(s_axis_tdata[30:16]);
    assign in_end  = in_base + in_cnt;

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, 9'(count_reg), 15'(total_reg), oas_reg, ost_reg};

    logic [PW:0] sum_tot;
    logic [PW-1:0] sat_tot;
    assign sum_tot = {1'b0, total_reg} + {1'b0, cnt_reg};
    assign sat_tot = (sum_tot > (PW + 1)'(NUM_PAGES)) ? PW'(NUM_PAGES) : sum_tot[PW-1:0];

    // Merge checks use the neighbour before (held) and the entry at idx_reg (held when the scan stopped).
    logic mprev, mnext, is_alloc;
    assign is_alloc = (kind_reg == ffpa_pkg::REQ_ALLOC);
    assign mprev = pvalid_reg && ((PW + 1)'(pstart_reg) + (PW + 1)'(plen_reg)
                                  == (PW + 1)'(base_reg));
    assign mnext = (idx_reg < count_reg)
                   && ((PW + 1)'(base_reg) + (PW + 1)'(cnt_reg) == (PW + 1)'(cstart_reg));

    always_comb
    begin
        we    = 1'b0;
        addr  = idx_reg[AW-1:0];
        wdata = fin_ent_reg;
        case (state_reg)
            S_SREQ:  addr = idx_reg[AW-1:0];
            S_MREQ:  addr = mv_up_reg ? AW'(mv_reg - 1'b1) : AW'(mv_reg + 1'b1);
            S_MMOV:
            begin
                we    = 1'b1;
                addr  = mv_reg[AW-1:0];
                wdata = rdata;
            end
            S_FIN:
            begin
                we   = fin_we_reg;
                addr = fin_addr_reg[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            total_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                begin
                    kind_reg   <= in_kind;
                    base_reg   <= in_base[PW-1:0];
                    cnt_reg    <= in_cnt[PW-1:0];
                    idx_reg    <= '0;
                    pvalid_reg <= 1'b0;
                    oas_reg    <= '0;
                    fin_we_reg <= 1'b0;
                    if (in_kind == ffpa_pkg::REQ_BAD)
                        ost_reg <= ffpa_pkg::ST_RANGE;
                    else if (in_cnt == '0)
                        ost_reg <= ffpa_pkg::ST_ZERO;
                    else if (in_kind == ffpa_pkg::REQ_ALLOC)
                        ost_reg <= (in_cnt > (PW + 1)'(total_reg))
                                   ? ffpa_pkg::ST_NOFIT : ffpa_pkg::ST_OK;
                    else if (in_end > (PW + 1)'(NUM_PAGES))
                        ost_reg <= ffpa_pkg::ST_RANGE;
                    else
                        ost_reg <= ffpa_pkg::ST_OK;
                end
                S_SCHK:
                begin
                    // Entry idx_reg is now on rdata.
                    if (is_alloc ? (rlen < cnt_reg) : (rstart <= base_reg))
                    begin
                        pstart_reg <= rstart;
                        plen_reg   <= rlen;
                        pvalid_reg <= 1'b1;
                        idx_reg    <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        cstart_reg <= rstart;
                        clen_reg   <= rlen;
                    end
                end
                S_DEC:
                begin
                    mv_reg  <= count_reg;
                    mv_up_reg  <= 1'b1;
                    mv_end_reg <= idx_reg;
                    fin_addr_reg <= idx_reg;
                    if (is_alloc)
                    begin
                        if (idx_reg >= count_reg)
                            ost_reg <= ffpa_pkg::ST_NOFIT;
                        else
                        begin
                            oas_reg   <= 14'(cstart_reg);
                            total_reg <= total_reg - cnt_reg;
                            if (clen_reg == cnt_reg)
                            begin
                                mv_reg     <= idx_reg;
                                mv_up_reg  <= 1'b0;
                                mv_end_reg <= count_reg - 1'b1;
                                count_reg  <= count_reg - 1'b1;
                            end
                            else
                            begin
                                fin_we_reg  <= 1'b1;
                                fin_ent_reg <= {cstart_reg + cnt_reg, clen_reg - cnt_reg};
                                mv_end_reg  <= count_reg;
                            end
                        end
                    end
                    else if (mprev && mnext && kind_reg == ffpa_pkg::REQ_FREE)
                    begin
                        total_reg    <= sat_tot;
                        fin_we_reg   <= 1'b1;
                        fin_addr_reg <= idx_reg - 1'b1;
                        fin_ent_reg  <= {pstart_reg, plen_reg + cnt_reg + clen_reg};
                        mv_reg       <= idx_reg;
                        mv_up_reg    <= 1'b0;
                        mv_end_reg   <= count_reg - 1'b1;
                        count_reg    <= count_reg - 1'b1;
                    end
                    else if (mprev && kind_reg == ffpa_pkg::REQ_FREE)
                    begin
                        total_reg    <= sat_tot;
                        fin_we_reg   <= 1'b1;
                        fin_addr_reg <= idx_reg - 1'b1;
                        fin_ent_reg  <= {pstart_reg, plen_reg + cnt_reg};
                        mv_end_reg   <= count_reg;
                    end
                    else if (mnext && kind_reg == ffpa_pkg::REQ_FREE)
                    begin
                        total_reg   <= sat_tot;
                        fin_we_reg  <= 1'b1;
                        fin_ent_reg <= {base_reg, clen_reg + cnt_reg};
                        mv_end_reg  <= count_reg;
                    end
                    else if (count_reg >= CW'(MAX_RUNS))
                        ost_reg <= ffpa_pkg::ST_FULL;
                    else
                    begin
                        total_reg   <= sat_tot;
                        fin_we_reg  <= 1'b1;
                        fin_ent_reg <= {base_reg, cnt_reg};
                        count_reg   <= count_reg + 1'b1;
                    end
                end
                S_MMOV:
                    mv_reg <= mv_up_reg ? mv_reg - 1'b1 : mv_reg + 1'b1;
                S_FIN:
                    ovalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                    state_next = S_SREQ;
            S_SREQ:
                if (ost_reg != ffpa_pkg::ST_OK)
                    state_next = S_FIN;
                else if (idx_reg >= count_reg)
                    state_next = S_DEC;
                else
                    state_next = S_SCHK;
            S_SCHK:
                if (is_alloc ? (rlen < cnt_reg) : (rstart <= base_reg))
                    state_next = S_SREQ;
                else
                    state_next = S_DEC;
            S_DEC:   state_next = S_MREQ;
            S_MREQ:
                if (ost_reg != ffpa_pkg::ST_OK || mv_reg == mv_end_reg)
                    state_next = S_FIN;
                else
                    state_next = S_MMOV;
            S_MMOV:  state_next = S_MREQ;
            S_FIN:   state_next = S_OUT;
            S_OUT:
                if (!ovalid_reg)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RUNS))
        else $error("run count above table size");
    a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= PW'(NUM_PAGES))
        else $error("free total above pool size");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !s_axis_tready)
        else $error("request taken while busy");
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE && state_reg != S_DEC |=> $stable(total_reg))
        else $error("free total changed outside decision");

endmodule
